FILE: src/single_server_drop_tail_queue_macros.svh
// Assertion macros used by the checker file.
`ifndef SINGLE_SERVER_DROP_TAIL_QUEUE_MACROS_SVH
`define SINGLE_SERVER_DROP_TAIL_QUEUE_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define SSTQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under a synchronous reset.
`define SSTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/sstq_pkg.sv
// Types and constants of the single-server drop-tail queue.
package sstq_pkg;

   localparam int DEPTH   = 64;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int LEN_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (LEN_W > 7) ? LEN_W : 7;
   localparam int ID_W    = 16;
   localparam int ADDR_W  = 16;
   localparam int JOB_W   = ID_W + ADDR_W;
   localparam int TICK_W  = 16;
   localparam int COUNT_W = 7;
   localparam int CAP_W   = 8;

   typedef enum logic {
      CMD_ARRIVE = 1'b0,
      CMD_TICK   = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_START  = 3'd1,
      EV_QUEUED = 3'd2,
      EV_DROP   = 3'd3,
      EV_DONE   = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      CSR_CAPACITY = 2'd0,
      CSR_SERVICE  = 2'd1,
      CSR_ADDRESS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      command_type        command;
      logic [ID_W-1:0]    job_id;
      logic [ADDR_W-1:0]  job_address;
   } item_type;

   typedef struct packed {
      logic [CAP_W-1:0]   queue_capacity;
      logic [TICK_W-1:0]  service_ticks;
      logic [ADDR_W-1:0]  own_address;
   } cfg_type;

   typedef struct packed {
      event_type           event_kind;
      logic [ID_W-1:0]     out_job_id;
      logic [ADDR_W-1:0]   out_job_address;
      logic                route_local;
      logic [COUNT_W-1:0]  waiting_count;
   } result_type;

endpackage

FILE: src/single_server_drop_tail_queue.sv
// Single server with a drop-tail FIFO waiting line: one arrival or tick per cycle while
// results are not stalled, one result for each. The rate of one item per cycle is set
// by the combinational update of the queue state; the waiting line is a 64-entry RAM
// whose head is read on completion and used from the next item on; no clearing pass
// follows reset. Write configuration only while no item is in flight.
module single_server_drop_tail_queue
   import sstq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // job_id[15:0], job_address[31:16]
   input  logic [0:0]  req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_job_id[15:0], out_job_address[31:16],
                                    // waiting_count[38:32], zero[39]
   output logic [3:0]  rsp_tuser,   // event_kind[2:0], route_local[3]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   cfg_type    cfg_ff, cfg_in;
   result_type result;
   logic       advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   sstq_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_item_in  = '{command:     command_type'(req_tuser[0]),
                         job_id:      req_tdata[15:0],
                         job_address: req_tdata[31:16]};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CAPACITY: cfg_in.queue_capacity = csr_data[CAP_W-1:0];
            CSR_SERVICE:  cfg_in.service_ticks  = csr_data;
            CSR_ADDRESS:  cfg_in.own_address    = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{queue_capacity: '1, service_ticks: TICK_W'(1), own_address: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.waiting_count, rsp_ff.out_job_address, rsp_ff.out_job_id};
   assign rsp_tuser  = {rsp_ff.route_local, rsp_ff.event_kind};

endmodule

FILE: src/sstq_ram.sv
// Generic single-port-write, registered-read RAM.
module sstq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sstq_engine.sv
// Queue and server state with the per-item update and result logic.
module sstq_engine
   import sstq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [PTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              busy_ff, busy_in;
   logic              from_ram_ff, from_ram_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [JOB_W-1:0]  job_ff, job_in;

   logic              ram_we, ram_re;
   logic [JOB_W-1:0]  ram_rdata;
   logic [JOB_W-1:0]  arrival_job, serving_job, out_job;
   logic [TICK_W-1:0] load_ticks, ticks_dec;
   logic              full;

   sstq_ram #(.WIDTH(JOB_W), .DEPTH(DEPTH)) u_wait_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (arrival_job),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign arrival_job = {item.job_id, item.job_address};
   assign serving_job = from_ram_ff ? ram_rdata : job_ff;
   assign load_ticks  = (cfg.service_ticks == '0) ? TICK_W'(1) : cfg.service_ticks;
   assign ticks_dec   = (ticks_ff != '0) ? ticks_ff - TICK_W'(1) : ticks_ff;
   assign full = (len_ff >= LEN_W'(DEPTH)) ||
                 (!cfg.queue_capacity[CAP_W-1] &&
                  (CMP_W'(len_ff) >= CMP_W'(cfg.queue_capacity[CAP_W-2:0])));

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      len_in      = len_ff;
      busy_in     = busy_ff;
      from_ram_in = from_ram_ff;
      ticks_in    = ticks_ff;
      job_in      = job_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      out_job     = '0;
      result      = '0;
      result.event_kind = EV_NONE;
      if (advance) begin
         if (item.command == CMD_ARRIVE) begin
            out_job = arrival_job;
            if (!busy_ff) begin
               busy_in     = 1'b1;
               job_in      = arrival_job;
               from_ram_in = 1'b0;
               ticks_in    = load_ticks;
               result.event_kind = EV_START;
            end else if (full) begin
               result.event_kind = EV_DROP;
            end else begin
               ram_we  = 1'b1;
               tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
               len_in  = len_ff + LEN_W'(1);
               result.event_kind = EV_QUEUED;
            end
         end else if (busy_ff) begin
            ticks_in = ticks_dec;
            if (ticks_dec == '0) begin
               out_job = serving_job;
               result.event_kind  = EV_DONE;
               result.route_local = (serving_job[ADDR_W-1:0] == cfg.own_address);
               if (len_ff == '0) begin
                  busy_in = 1'b0;
               end else begin
                  ram_re      = 1'b1;
                  from_ram_in = 1'b1;
                  head_in  = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
                  len_in   = len_ff - LEN_W'(1);
                  ticks_in = load_ticks;
               end
            end
         end
      end
      result.out_job_id      = out_job[JOB_W-1:ADDR_W];
      result.out_job_address = out_job[ADDR_W-1:0];
      result.waiting_count   = COUNT_W'(len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         len_ff      <= '0;
         busy_ff     <= 1'b0;
         from_ram_ff <= 1'b0;
         ticks_ff    <= '0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         len_ff      <= len_in;
         busy_ff     <= busy_in;
         from_ram_ff <= from_ram_in;
         ticks_ff    <= ticks_in;
      end
      job_ff <= job_in;
   end

endmodule

FILE: src/sstq_checker.sv
// Port-level checks of the queue's result stream, bound to the top level.
`include "single_server_drop_tail_queue_macros.svh"

module sstq_checker
   import sstq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   `SSTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `SSTQ_ASSERT_IMPLY(a_route_on_done, clock, reset, rsp_tvalid && rsp_tuser[3],
                      rsp_tuser[2:0] == EV_DONE)
   `SSTQ_ASSERT_IMPLY(a_none_empty, clock, reset, rsp_tvalid && rsp_tuser[2:0] == EV_NONE,
                      rsp_tdata[31:0] == 32'd0 && !rsp_tuser[3])
   `SSTQ_ASSERT_IMPLY(a_queued_count, clock, reset, rsp_tvalid && rsp_tuser[2:0] == EV_QUEUED,
                      rsp_tdata[38:32] != 7'd0)

endmodule

bind single_server_drop_tail_queue sstq_checker u_sstq_checker (.*);
